// ===== hdl/aes_pkg.sv =====
// aes cbc package: payload types, state encoding and cipher helper functions
package aes_pkg;

  typedef struct packed {
    logic [63:0] plain_hi;
    logic [63:0] plain_lo;
    logic        first_block;
  } in_item_t;

  typedef struct packed {
    logic [63:0] cipher_hi;
    logic [63:0] cipher_lo;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_KEXP, ST_ARK0, ST_SUB, ST_MIX, ST_ARK, ST_DONE
  } state_e;

  localparam logic [2:0] REG_KEY_SIZE = 3'd0;
  localparam logic [2:0] REG_KEY_A    = 3'd1;
  localparam logic [2:0] REG_KEY_B    = 3'd2;
  localparam logic [2:0] REG_KEY_C    = 3'd3;
  localparam logic [2:0] REG_KEY_D    = 3'd4;
  localparam logic [2:0] REG_IV_HI    = 3'd5;
  localparam logic [2:0] REG_IV_LO    = 3'd6;

  localparam int KeyWords = 60;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] x);
    return {SBOX[x[31:24]], SBOX[x[23:16]], SBOX[x[15:8]], SBOX[x[7:0]]};
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c);
    logic [7:0] a0, a1, a2, a3, al;
    a0 = c[31:24];
    a1 = c[23:16];
    a2 = c[15:8];
    a3 = c[7:0];
    al = a0 ^ a1 ^ a2 ^ a3;
    return {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
            a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
  endfunction

endpackage

// ===== hdl/aes_cbc_encrypt_unit.sv =====
// aes cbc encrypt top level: key schedule memory and word-serial round datapath
// an accepted item runs key expansion first if first_block is set, then add round key and
// nr rounds (nr = 10, 12, 14) of sub bytes, shift rows, mix columns (not in the last round)
// and add round key; one item at a time; an unread result stalls the next one at its end
// state moves as a 4-word shift register, one 32-bit column per cycle when not stalled
// reset clears control, config registers (key size 256-bit) and chain value, not round keys
module aes_cbc_encrypt_unit (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  aes_pkg::in_item_t   in_data_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output aes_pkg::out_item_t  out_data_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [2:0]          cfg_index_i,
  input  logic [63:0]         cfg_data_i
);
  import aes_pkg::*;

  state_e state_q, state_d;
  logic [1:0]  ksize_q;
  logic [63:0] key_a_q, key_b_q, key_c_q, key_d_q, iv_hi_q, iv_lo_q;
  logic [127:0] chain_q;
  logic [3:0]  nr_q;
  logic [3:0]  nk_q;
  logic [31:0] st_q [4];
  logic [31:0] rk_mem [KeyWords];
  logic [5:0]  ki_q;
  logic [5:0]  ktot_q;
  logic [2:0]  kmod_q;
  logic [3:0]  kdiv_q;
  logic [31:0] win_q [8];
  logic [1:0]  col_q;
  logic [3:0]  rd_q;
  logic [31:0] rk_rd_q;
  logic        rk_ok_q;
  logic [127:0] res_q;
  logic        out_v_q;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_v_q;
  assign out_data_o  = '{cipher_hi: res_q[127:64], cipher_lo: res_q[63:0]};

  logic in_go;
  assign in_go = in_valid_i && in_ready_o;

  // last column of the last round
  logic fin_last, fin_stall, fin_go;
  assign fin_last  = (state_q == ST_ARK) && rk_ok_q && (col_q == 2'd3) && (rd_q == nr_q);
  assign fin_stall = fin_last && out_v_q && !out_ready_i;
  assign fin_go    = fin_last && !fin_stall;

  // round key read address
  logic [5:0] rk_addr;
  always_comb begin
    rk_addr = {rd_q, col_q + {1'b0, rk_ok_q && (col_q != 2'd3)}};
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_go) state_d = in_data_i.first_block ? ST_KEXP : ST_ARK0;
      ST_KEXP: if (ki_q == ktot_q) state_d = ST_ARK0;
      ST_ARK0: if (col_q == 2'd3 && rk_ok_q) state_d = ST_SUB;
      ST_SUB:  if (col_q == 2'd3) state_d = (rd_q == nr_q) ? ST_ARK : ST_MIX;
      ST_MIX:  if (col_q == 2'd3) state_d = ST_ARK;
      ST_ARK:  if (col_q == 2'd3 && rk_ok_q && !fin_stall)
                 state_d = (rd_q == nr_q) ? ST_DONE : ST_SUB;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // key expansion word
  logic [31:0] kprev, knew, kt;
  logic [7:0]  rcon;
  always_comb begin
    kprev = win_q[nk_q[2:0] - 3'd1];
    case (kdiv_q)
      4'd1: rcon = 8'h01;
      4'd2: rcon = 8'h02;
      4'd3: rcon = 8'h04;
      4'd4: rcon = 8'h08;
      4'd5: rcon = 8'h10;
      4'd6: rcon = 8'h20;
      4'd7: rcon = 8'h40;
      4'd8: rcon = 8'h80;
      4'd9: rcon = 8'h1b;
      4'd10: rcon = 8'h36;
      default: rcon = 8'h00;
    endcase
    if (kmod_q == 3'd0) begin
      kt = sub_word({kprev[23:0], kprev[31:24]}) ^ {rcon, 24'h0};
    end else if (nk_q == 4'd8 && kmod_q == 3'd4) begin
      kt = sub_word(kprev);
    end else begin
      kt = kprev;
    end
    knew = win_q[0] ^ kt;
  end

  // column datapath
  logic [31:0] col_sub, col_mix, col_ark;
  logic [31:0] sb_col [4];
  logic [31:0] sr_col [4];
  always_comb begin
    col_sub = sub_word(st_q[0]);
    col_mix = mix_col(st_q[0]);
    col_ark = st_q[0] ^ rk_rd_q;
    sb_col[0] = st_q[1];
    sb_col[1] = st_q[2];
    sb_col[2] = st_q[3];
    sb_col[3] = col_sub;
    sr_col[0] = {sb_col[0][31:24], sb_col[1][23:16], sb_col[2][15:8], sb_col[3][7:0]};
    sr_col[1] = {sb_col[1][31:24], sb_col[2][23:16], sb_col[3][15:8], sb_col[0][7:0]};
    sr_col[2] = {sb_col[2][31:24], sb_col[3][23:16], sb_col[0][15:8], sb_col[1][7:0]};
    sr_col[3] = {sb_col[3][31:24], sb_col[0][23:16], sb_col[1][15:8], sb_col[2][7:0]};
  end

  logic [127:0] x_in;
  assign x_in = {in_data_i.plain_hi, in_data_i.plain_lo} ^
                (in_data_i.first_block ? {iv_hi_q, iv_lo_q} : chain_q);

  always_ff @(posedge clk_i) begin
    rk_rd_q <= rk_mem[rk_addr];
    if (state_q == ST_KEXP && ki_q != ktot_q) begin
      rk_mem[ki_q] <= (ki_q < {2'b0, nk_q}) ? win_q[0] : knew;
    end
  end

  logic [1:0] ksel;
  assign ksel = (ksize_q == 2'd3) ? 2'd2 : ksize_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ksize_q <= 2'd2;
      key_a_q <= '0;
      key_b_q <= '0;
      key_c_q <= '0;
      key_d_q <= '0;
      iv_hi_q <= '0;
      iv_lo_q <= '0;
      chain_q <= '0;
      nr_q    <= 4'd14;
      nk_q    <= 4'd8;
      out_v_q <= 1'b0;
      col_q   <= '0;
      rd_q    <= '0;
      rk_ok_q <= 1'b0;
      ki_q    <= '0;
      ktot_q  <= '0;
      kmod_q  <= '0;
      kdiv_q  <= '0;
      st_q    <= '{default: '0};
      win_q   <= '{default: '0};
      res_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_valid_i) begin
        unique case (cfg_index_i)
          REG_KEY_SIZE: ksize_q <= cfg_data_i[1:0];
          REG_KEY_A:    key_a_q <= cfg_data_i;
          REG_KEY_B:    key_b_q <= cfg_data_i;
          REG_KEY_C:    key_c_q <= cfg_data_i;
          REG_KEY_D:    key_d_q <= cfg_data_i;
          REG_IV_HI:    iv_hi_q <= cfg_data_i;
          REG_IV_LO:    iv_lo_q <= cfg_data_i;
          default: ;
        endcase
      end
      if (fin_go) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          col_q <= '0;
          rd_q  <= '0;
          if (in_go) begin
            st_q[0] <= x_in[127:96];
            st_q[1] <= x_in[95:64];
            st_q[2] <= x_in[63:32];
            st_q[3] <= x_in[31:0];
            if (in_data_i.first_block) begin
              nk_q   <= 4'd4 + {1'b0, ksel, 1'b0};
              nr_q   <= 4'd10 + {1'b0, ksel, 1'b0};
              ktot_q <= 6'd44 + {1'b0, ksel, 3'b0};
              ki_q   <= '0;
              kmod_q <= '0;
              kdiv_q <= '0;
              win_q[0] <= key_a_q[63:32];
              win_q[1] <= key_a_q[31:0];
              win_q[2] <= key_b_q[63:32];
              win_q[3] <= key_b_q[31:0];
              win_q[4] <= key_c_q[63:32];
              win_q[5] <= key_c_q[31:0];
              win_q[6] <= key_d_q[63:32];
              win_q[7] <= key_d_q[31:0];
            end
          end
        end
        ST_KEXP: begin
          if (ki_q != ktot_q) begin
            ki_q <= ki_q + 6'd1;
            if (kmod_q == nk_q[2:0] - 3'd1 || (nk_q == 4'd8 && kmod_q == 3'd7)) begin
              kmod_q <= '0;
              kdiv_q <= kdiv_q + 4'd1;
            end else begin
              kmod_q <= kmod_q + 3'd1;
            end
            // window of the last nk words, oldest at position 0
            for (int i = 0; i < 7; i++) begin
              if (i < nk_q - 1) win_q[i] <= win_q[i + 1];
            end
            win_q[nk_q[2:0] - 3'd1] <= (ki_q < {2'b0, nk_q}) ? win_q[0] : knew;
          end
        end
        ST_ARK0, ST_ARK: begin
          if (!rk_ok_q) begin
            rk_ok_q <= 1'b1;
          end else if (!fin_stall) begin
            st_q[0] <= st_q[1];
            st_q[1] <= st_q[2];
            st_q[2] <= st_q[3];
            st_q[3] <= col_ark;
            col_q <= col_q + 2'd1;
            rk_ok_q <= (col_q != 2'd3);
            if (col_q == 2'd3) begin
              rd_q <= rd_q + 4'd1;
            end
            if (fin_go) begin
              res_q   <= {st_q[1], st_q[2], st_q[3], col_ark};
              chain_q <= {st_q[1], st_q[2], st_q[3], col_ark};
            end
          end
        end
        ST_SUB: begin
          // sub one column per cycle, shiftrows on the last one
          if (col_q == 2'd3) begin
            st_q[0] <= sr_col[0];
            st_q[1] <= sr_col[1];
            st_q[2] <= sr_col[2];
            st_q[3] <= sr_col[3];
          end else begin
            st_q[0] <= st_q[1];
            st_q[1] <= st_q[2];
            st_q[2] <= st_q[3];
            st_q[3] <= col_sub;
          end
          col_q <= col_q + 2'd1;
        end
        ST_MIX: begin
          st_q[0] <= st_q[1];
          st_q[1] <= st_q[2];
          st_q[2] <= st_q[3];
          st_q[3] <= col_mix;
          col_q <= col_q + 2'd1;
        end
        ST_DONE: ;
        default: ;
      endcase
    end
  end

endmodule
